>>> rtl/gwm_pkg.sv
// gwm_pkg: shared types, character codes and helpers for the glob matcher
// no dependencies; imported by every module of the block
package gwm_pkg;

   typedef enum logic [1:0] {
      KIND_PAT  = 2'd0,
      KIND_NAME = 2'd1,
      KIND_END  = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  value;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DECODE,
      ST_ESC,
      ST_CLS_NEG,
      ST_CLS_ITEM,
      ST_CLS_R1,
      ST_CLS_R2,
      ST_TAIL,
      ST_DONE
   } state_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_RBRK  = 8'h5D;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_UPA   = 8'h41;
   localparam logic [7:0] CH_UPZ   = 8'h5A;
   localparam logic [7:0] CASE_OFS = 8'h20;

   // fold ascii upper case to lower when enabled
   function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
      if (en && c >= CH_UPA && c <= CH_UPZ) begin
         return c + CASE_OFS;
      end
      return c;
   endfunction

endpackage

>>> rtl/gwm_front.sv
// gwm_front: accepts input items, drops ones with no effect, queues commands
// depends on gwm_pkg; feeds gwm_engine through a two-entry queue
module gwm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic [1:0]       req_tuser,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output gwm_pkg::cmd_type cmd
);
   import gwm_pkg::*;

   cmd_type    slot_ff [2];
   cmd_type    slot_in [2];
   logic [1:0] count_ff, count_in;
   logic       keep;
   logic       push, pop;
   cmd_type    incoming;

   // classify: unknown kinds and zero bytes are dropped
   always_comb begin
      incoming.kind  = kind_type'(req_tuser);
      incoming.value = req_tdata;
      case (incoming.kind)
         KIND_PAT, KIND_NAME: keep = (req_tdata != CH_NUL);
         KIND_END:            keep = 1'b1;
         default:             keep = 1'b0;
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready && keep;
   assign cmd_valid  = (count_ff != 2'd0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = slot_ff[0];

   // two-entry shift queue
   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (push) begin
         if (pop) begin
            slot_in[count_ff[1]] = incoming;
         end else begin
            slot_in[count_ff[0]] = incoming;
         end
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/gwm_engine.sv
// gwm_engine: pattern and name stores, match sequencer and result register
// depends on gwm_pkg; takes commands from gwm_front
module gwm_engine #(
   parameter int PATTERN_DEPTH = 64,
   parameter int NAME_DEPTH    = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fold_case,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  gwm_pkg::cmd_type cmd,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata
);
   import gwm_pkg::*;

   localparam int PA = $clog2(PATTERN_DEPTH);
   localparam int PW = PA + 2;
   localparam int NA = $clog2(NAME_DEPTH);
   localparam int NW = NA + 1;

   logic [7:0] pat_mem  [PATTERN_DEPTH];
   logic [7:0] name_mem [NAME_DEPTH];

   state_type   state_ff, state_in;
   logic [PA:0] plen_ff, plen_in;
   logic [NW-1:0] nlen_ff, nlen_in;
   logic        ovf_ff, ovf_in;
   logic [PW-1:0] p_ff, p_in, star_ff, star_in, q_ff, q_in, first_ff, first_in;
   logic [NW-1:0] n_ff, n_in, retry_ff, retry_in;
   logic        have_ff, have_in, neg_ff, neg_in, hit_ff, hit_in;
   logic        res_ff, res_in;
   logic [7:0]  nc_ff, nc_in, lo_ff, lo_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_match_ff, rsp_match_in, rsp_ovf_ff, rsp_ovf_in;

   logic [PW-1:0] pat_raddr;
   logic [7:0]    pat_rd_ff, name_rd_ff, pd, nc_now, fhi;
   logic          pat_inr_ff;
   logic          pat_we, name_we;

   // stores: one write and one registered read each
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[plen_ff[PA-1:0]] <= cmd.value;
      end
      if (name_we) begin
         name_mem[nlen_ff[NA-1:0]] <= cmd.value;
      end
      pat_rd_ff  <= pat_mem[pat_raddr[PA-1:0]];
      pat_inr_ff <= (pat_raddr < PW'(plen_ff));
      name_rd_ff <= name_mem[n_ff[NA-1:0]];
   end

   // pattern byte, zero past the end
   assign pd     = pat_inr_ff ? pat_rd_ff : CH_NUL;
   assign nc_now = fold(name_rd_ff, fold_case);
   assign fhi    = fold(pd, fold_case);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ovf_ff, rsp_match_ff};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      plen_in      = plen_ff;
      nlen_in      = nlen_ff;
      ovf_in       = ovf_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      star_in      = star_ff;
      retry_in     = retry_ff;
      have_in      = have_ff;
      q_in         = q_ff;
      first_in     = first_ff;
      neg_in       = neg_ff;
      hit_in       = hit_ff;
      lo_in        = lo_ff;
      nc_in        = nc_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_match_in = rsp_match_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      pat_raddr    = p_ff;
      pat_we       = 1'b0;
      name_we      = 1'b0;
      cmd_ready    = 1'b0;
      // a failed step backtracks to the last star or ends with no match
      begin : fail_path
         logic fail;
         fail = 1'b0;
         case (state_ff)
            ST_IDLE: begin
               cmd_ready = 1'b1;
               if (cmd_valid) begin
                  case (cmd.kind)
                     KIND_PAT: begin
                        if (plen_ff < (PA+1)'(PATTERN_DEPTH)) begin
                           pat_we  = 1'b1;
                           plen_in = plen_ff + 1'b1;
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                     KIND_NAME: begin
                        if (nlen_ff < NW'(NAME_DEPTH)) begin
                           name_we = 1'b1;
                           nlen_in = nlen_ff + 1'b1;
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                     KIND_END: begin
                        p_in    = '0;
                        n_in    = '0;
                        have_in = 1'b0;
                        res_in  = 1'b0;
                        state_in = ovf_ff ? ST_DONE : ST_FETCH;
                     end
                     default: ;
                  endcase
               end
            end
            ST_FETCH: begin
               pat_raddr = p_ff;
               state_in  = (n_ff < nlen_ff) ? ST_DECODE : ST_TAIL;
            end
            ST_DECODE: begin
               nc_in = nc_now;
               case (pd)
                  CH_BSL: begin
                     pat_raddr = p_ff + 1'b1;
                     state_in  = ST_ESC;
                  end
                  CH_QUEST: begin
                     p_in     = p_ff + 1'b1;
                     n_in     = n_ff + 1'b1;
                     state_in = ST_FETCH;
                  end
                  CH_STAR: begin
                     p_in     = p_ff + 1'b1;
                     star_in  = p_ff + 1'b1;
                     retry_in = n_ff;
                     have_in  = 1'b1;
                     state_in = ST_FETCH;
                  end
                  CH_LBRK: begin
                     pat_raddr = p_ff + 1'b1;
                     q_in      = p_ff + 1'b1;
                     hit_in    = 1'b0;
                     state_in  = ST_CLS_NEG;
                  end
                  default: begin
                     if (pd != CH_NUL && fhi == nc_now) begin
                        p_in     = p_ff + 1'b1;
                        n_in     = n_ff + 1'b1;
                        state_in = ST_FETCH;
                     end else begin
                        fail = 1'b1;
                     end
                  end
               endcase
            end
            ST_ESC: begin
               if (pd != CH_NUL) begin
                  if (fhi == nc_ff) begin
                     p_in     = p_ff + PW'(2);
                     n_in     = n_ff + 1'b1;
                     state_in = ST_FETCH;
                  end else begin
                     fail = 1'b1;
                  end
               end else if (nc_ff == CH_BSL) begin
                  // lone trailing backslash is a literal
                  p_in     = p_ff + 1'b1;
                  n_in     = n_ff + 1'b1;
                  state_in = ST_FETCH;
               end else begin
                  fail = 1'b1;
               end
            end
            ST_CLS_NEG: begin
               if (pd == CH_BANG || pd == CH_CARET) begin
                  neg_in    = 1'b1;
                  q_in      = q_ff + 1'b1;
                  first_in  = q_ff + 1'b1;
                  pat_raddr = q_ff + 1'b1;
               end else begin
                  neg_in    = 1'b0;
                  first_in  = q_ff;
                  pat_raddr = q_ff;
               end
               state_in = ST_CLS_ITEM;
            end
            ST_CLS_ITEM: begin
               if (pd == CH_NUL) begin
                  fail = 1'b1;
               end else if (pd == CH_RBRK && q_ff != first_ff) begin
                  if (hit_ff != neg_ff) begin
                     p_in     = q_ff + 1'b1;
                     n_in     = n_ff + 1'b1;
                     state_in = ST_FETCH;
                  end else begin
                     fail = 1'b1;
                  end
               end else begin
                  lo_in     = fhi;
                  pat_raddr = q_ff + 1'b1;
                  state_in  = ST_CLS_R1;
               end
            end
            ST_CLS_R1: begin
               if (pd == CH_DASH) begin
                  pat_raddr = q_ff + PW'(2);
                  state_in  = ST_CLS_R2;
               end else begin
                  if (lo_ff == nc_ff) begin
                     hit_in = 1'b1;
                  end
                  q_in      = q_ff + 1'b1;
                  pat_raddr = q_ff + 1'b1;
                  state_in  = ST_CLS_ITEM;
               end
            end
            ST_CLS_R2: begin
               if (pd != CH_NUL && pd != CH_RBRK) begin
                  if (nc_ff >= lo_ff && nc_ff <= fhi) begin
                     hit_in = 1'b1;
                  end
                  q_in      = q_ff + PW'(3);
                  pat_raddr = q_ff + PW'(3);
               end else begin
                  if (lo_ff == nc_ff) begin
                     hit_in = 1'b1;
                  end
                  q_in      = q_ff + 1'b1;
                  pat_raddr = q_ff + 1'b1;
               end
               state_in = ST_CLS_ITEM;
            end
            ST_TAIL: begin
               // trailing stars match empty
               if (pd == CH_STAR) begin
                  p_in      = p_ff + 1'b1;
                  pat_raddr = p_ff + 1'b1;
               end else begin
                  res_in   = (pd == CH_NUL);
                  state_in = ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_in = 1'b1;
                  rsp_match_in = res_ff && !ovf_ff;
                  rsp_ovf_in   = ovf_ff;
                  plen_in      = '0;
                  nlen_in      = '0;
                  ovf_in       = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
            default: state_in = ST_IDLE;
         endcase
         if (fail) begin
            if (have_ff) begin
               p_in     = star_ff;
               retry_in = retry_ff + 1'b1;
               n_in     = retry_ff + 1'b1;
               state_in = ST_FETCH;
            end else begin
               res_in   = 1'b0;
               state_in = ST_DONE;
            end
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      n_ff         <= n_in;
      star_ff      <= star_in;
      retry_ff     <= retry_in;
      have_ff      <= have_in;
      q_ff         <= q_in;
      first_ff     <= first_in;
      neg_ff       <= neg_in;
      hit_ff       <= hit_in;
      lo_ff        <= lo_in;
      nc_ff        <= nc_in;
      res_ff       <= res_in;
      rsp_match_ff <= rsp_match_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         plen_ff      <= '0;
         nlen_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plen_ff      <= plen_in;
         nlen_ff      <= nlen_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/wildcard_glob_matcher.sv
// wildcard_glob_matcher: glob match of a stored name against a stored pattern
// byte items load at one per cycle while the engine is idle and the queue has room;
// an end item runs the match sequencer, which fetches each pattern byte and then
// decodes it, with extra states for an escape and for a class; a failed step retries
// one name position after the last star; a held result stalls the input
// reset (synchronous) empties both stores, clears overflow and fold_case; uses gwm_pkg,
// gwm_front and gwm_engine
module wildcard_glob_matcher #(
   parameter int PATTERN_DEPTH = 64,
   parameter int NAME_DEPTH    = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_value
   input  logic [1:0] req_tuser,   // [1:0] kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] matched, [1] overflowed, [7:2] zero
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data     // fold_case
);
   import gwm_pkg::*;

   logic    fold_ff;
   logic    cmd_valid, cmd_ready;
   cmd_type cmd;

   assign csr_ready = 1'b1;

   // case-fold register
   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff <= 1'b0;
      end else if (csr_valid) begin
         fold_ff <= csr_data;
      end
   end

   gwm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   gwm_engine #(
      .PATTERN_DEPTH (PATTERN_DEPTH),
      .NAME_DEPTH    (NAME_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .fold_case  (fold_ff),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> bench/wildcard_glob_matcher_tb.sv
// wildcard_glob_matcher_tb: self-checking bench for the glob matcher, with its own
// match predictor, directed and random stimulus, random idling and a receiver hold-off
// depends on gwm_pkg and the wildcard_glob_matcher rtl
module wildcard_glob_matcher_tb;
   import gwm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAT_DEPTH   = 64;
   localparam int NAME_DEPTH  = 256;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN       = 40;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_tvalid = 0;
   logic       req_tready;
   logic [7:0] req_tdata = 0;
   logic [1:0] req_tuser = 0;
   logic       rsp_tvalid;
   logic       rsp_tready = 0;
   logic [7:0] rsp_tdata;
   logic       csr_valid = 0;
   logic       csr_ready;
   logic       csr_data = 0;

   // predictor state
   logic [7:0]    pat_bytes[$];
   logic [7:0]    name_bytes[$];
   bit            store_overflow = 0;
   bit            fold_on = 0;
   logic [1:0]    verdict_q[$];   // {overflowed, matched}
   idle_mode_type idle_mode = IDLE_NONE;
   int            hold_left = 0;
   int            mismatches = 0;
   int            cycles = 0;

   wildcard_glob_matcher dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic bit roll(int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic logic [7:0] to_lower(logic [7:0] c);
      if (fold_on && c >= "A" && c <= "Z") begin
         return c + 8'd32;
      end
      return c;
   endfunction

   function automatic logic [7:0] pat_at(int i);
      return (i < pat_bytes.size()) ? pat_bytes[i] : CH_NUL;
   endfunction

   // glob walk with one backtrack point at the latest star
   function automatic bit glob_walk();
      int p = 0, n = 0, star = 0, retry = 0, q, first;
      bit have_star = 0, neg, hit;
      logic [7:0] pc, nc, qc, lo, hi;
      while (n < name_bytes.size()) begin
         pc = pat_at(p);
         nc = to_lower(name_bytes[n]);
         if (pc == CH_BSL && pat_at(p + 1) != CH_NUL) begin
            if (to_lower(pat_at(p + 1)) == nc) begin
               p += 2; n++; continue;
            end
         end else if (pc == CH_QUEST) begin
            p++; n++; continue;
         end else if (pc == CH_STAR) begin
            p++; star = p; retry = n; have_star = 1; continue;
         end else if (pc == CH_LBRK) begin
            q = p + 1; neg = 0; hit = 0;
            qc = pat_at(q);
            if (qc == CH_BANG || qc == CH_CARET) begin
               neg = 1; q++;
            end
            first = q;
            forever begin
               qc = pat_at(q);
               if (qc == CH_NUL || (qc == CH_RBRK && q != first)) break;
               lo = to_lower(qc);
               if (pat_at(q + 1) == CH_DASH && pat_at(q + 2) != CH_NUL
                   && pat_at(q + 2) != CH_RBRK) begin
                  hi = to_lower(pat_at(q + 2));
                  if (nc >= lo && nc <= hi) hit = 1;
                  q += 2;
               end else if (lo == nc) begin
                  hit = 1;
               end
               q++;
            end
            if (pat_at(q) == CH_RBRK && hit != neg) begin
               p = q + 1; n++; continue;
            end
         end else if (pc != CH_NUL && to_lower(pc) == nc) begin
            p++; n++; continue;
         end
         if (!have_star) return 0;
         p = star; retry++; n = retry;
      end
      while (pat_at(p) == CH_STAR) p++;
      return pat_at(p) == CH_NUL;
   endfunction

   // update the predictor with one accepted item
   task automatic absorb_item(kind_type k, logic [7:0] v);
      bit m;
      case (k)
         KIND_PAT: begin
            if (v != CH_NUL) begin
               if (pat_bytes.size() < PAT_DEPTH) pat_bytes.push_back(v);
               else store_overflow = 1;
            end
         end
         KIND_NAME: begin
            if (v != CH_NUL) begin
               if (name_bytes.size() < NAME_DEPTH) name_bytes.push_back(v);
               else store_overflow = 1;
            end
         end
         KIND_END: begin
            m = store_overflow ? 0 : glob_walk();
            verdict_q.push_back({store_overflow, m});
            pat_bytes.delete();
            name_bytes.delete();
            store_overflow = 0;
         end
         default: ;
      endcase
   endtask

   // offer one item, idling first as the phase asks; valid stays up afterwards
   task automatic send_item(kind_type k, logic [7:0] v);
      int pct;
      pct = (idle_mode == IDLE_SENDER) ? 76 : (idle_mode == IDLE_BOTH) ? 6 : 0;
      while (roll(pct)) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= k;
      req_tdata  <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_item(k, v);
   endtask

   task automatic send_text(kind_type k, string s);
      for (int i = 0; i < s.len(); i++) send_item(k, s[i]);
   endtask

   task automatic run_case(string pat, string nam);
      send_text(KIND_PAT, pat);
      send_text(KIND_NAME, nam);
      send_item(KIND_END, 8'h00);
   endtask

   // wait for every result, then let the block go quiet
   task automatic settle();
      req_tvalid <= 0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_fold(bit v);
      settle();
      csr_valid <= 1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      fold_on = v;
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      logic [1:0] want;
      int pct;
      pct = (idle_mode == IDLE_RECEIVER) ? 76 : (idle_mode == IDLE_BOTH) ? 6 : 0;
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= !roll(pct);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_tdata[0] !== want[0] || rsp_tdata[1] !== want[1]
                || rsp_tdata[7:2] !== 6'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: matched exp %0d got %0d, overflowed exp %0d got %0d",
                           want[0], rsp_tdata[0], want[1], rsp_tdata[1]);
            end
         end
      end
   end

   // each special case and operation once
   task automatic test_directed();
      run_case("", "");
      run_case("", "a");
      run_case("a?c", "abc");
      run_case("*", "xyz");
      run_case("a**", "a");
      run_case("\\*", "*");
      run_case("ab\\", "ab\\");
      run_case("[!a-c]x", "dx");
      run_case("[]a]", "]");
      run_case("[^b]", "b");
      run_case("*[ab", "x[ab");
      run_case("*b", "abab");
      // zero bytes and the unused kind are ignored
      send_item(KIND_PAT, 8'h00);
      send_item(KIND_NONE, 8'hFF);
      send_item(KIND_PAT, 8'hFF);
      send_item(KIND_NAME, 8'h00);
      send_item(KIND_NAME, 8'hFF);
      send_item(KIND_END, 8'h00);
      run_case("[\x01-\xff]", "\x80");
   endtask

   task automatic test_fold_case();
      write_fold(1);
      run_case("ABC", "abc");
      run_case("[A-Z]?", "qR");
      run_case("\\A*", "aBc");
      write_fold(0);
      run_case("ABC", "abc");
   endtask

   task automatic test_overflow();
      for (int i = 0; i < PAT_DEPTH + 1; i++) send_item(KIND_PAT, "*");
      send_item(KIND_END, 8'h00);
      for (int i = 0; i < PAT_DEPTH; i++) send_item(KIND_PAT, "?");
      for (int i = 0; i < PAT_DEPTH; i++) send_item(KIND_NAME, "z");
      send_item(KIND_END, 8'h00);
      send_item(KIND_PAT, "*");
      for (int i = 0; i < NAME_DEPTH + 2; i++) send_item(KIND_NAME, 8'($urandom_range(1, 255)));
      send_item(KIND_END, 8'h00);
   endtask

   // random name, then a pattern mostly derived from it so that matches happen
   task automatic random_case(bit long_one);
      string alpha, meta, nam, pat;
      int nlen, plen;
      logic [7:0] c;
      alpha = "abAB]-";
      meta  = "ab*?[]!^-\\A";
      nam = ""; pat = "";
      nlen = long_one ? $urandom_range(NAME_DEPTH - 8, NAME_DEPTH) : $urandom_range(0, 8);
      for (int i = 0; i < nlen; i++) begin
         c = roll(10) ? 8'($urandom_range(1, 255)) : alpha[$urandom_range(alpha.len() - 1)];
         nam = {nam, string'(c)};
      end
      if (roll(65)) begin
         for (int i = 0; i < nlen && pat.len() < PAT_DEPTH - 6; i++) begin
            case ($urandom_range(7))
               0: pat = {pat, "?"};
               1: pat = {pat, "*"};
               2: pat = {pat, "\\", string'(nam[i])};
               3: pat = {pat, "[", roll(30) ? "!" : "", string'(nam[i]), "-z]"};
               4: pat = {pat, string'(meta[$urandom_range(meta.len() - 1)])};
               default: pat = {pat, string'(nam[i])};
            endcase
         end
         if (roll(20)) pat = {pat, "*"};
      end else begin
         plen = long_one ? $urandom_range(PAT_DEPTH - 4, PAT_DEPTH) : $urandom_range(0, 8);
         for (int i = 0; i < plen; i++) begin
            c = roll(8) ? 8'($urandom_range(1, 255)) : meta[$urandom_range(meta.len() - 1)];
            pat = {pat, string'(c)};
         end
      end
      if (roll(5)) send_item(kind_type'($urandom_range(3)), 8'($urandom_range(255)));
      run_case(pat, nam);
   endtask

   task automatic test_random(idle_mode_type mode, int cases);
      settle();
      idle_mode = mode;
      for (int i = 0; i < cases; i++) random_case(roll(2));
   endtask

   // receiver holds off while items keep coming
   task automatic test_backpressure();
      settle();
      idle_mode = IDLE_NONE;
      hold_left = 400;
      for (int i = 0; i < 30; i++) run_case("a*", "ab");
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_fold_case();
      test_overflow();
      test_backpressure();
      test_random(IDLE_NONE, 20);
      write_fold(1);
      test_random(IDLE_SENDER, 15);
      test_random(IDLE_RECEIVER, 15);
      write_fold(0);
      test_random(IDLE_BOTH, 15);
      settle();
      if (mismatches == 0 && verdict_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
